// File: hdl/jbcs_pkg.sv
package jbcs_pkg;

	// scan mode codes
	localparam logic [2:0] MODE_NORMAL  = 3'd0;
	localparam logic [2:0] MODE_SLASH   = 3'd1;
	localparam logic [2:0] MODE_STRING  = 3'd2;
	localparam logic [2:0] MODE_ESCAPE  = 3'd3;
	localparam logic [2:0] MODE_COMMENT = 3'd4;
	localparam logic [2:0] MODE_STAR    = 3'd5;

	// characters of interest
	localparam logic [7:0] CHAR_SLASH     = 8'h2F;
	localparam logic [7:0] CHAR_STAR      = 8'h2A;
	localparam logic [7:0] CHAR_QUOTE     = 8'h22;
	localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;

	// result queue address width, depth is a power of two; keep it at least 8 (unchecked)
	localparam int QUEUE_AW_DEFAULT = 3;

	// one result request
	typedef struct packed {
		logic [7:0] data;
		logic       byte_valid;
		logic       text_end;
	} res_t;

endpackage

// File: hdl/json_block_comment_stripper.sv
// Block comment stripper for JSON text: removes /* ... */ comments outside string
// literals when allow_comments is set, and passes every byte through otherwise.
// One byte is accepted per cycle while in_stall is low. An accepted byte is
// registered, classified combinationally against the scan mode, and its zero, one or
// two results are pushed into a registered result queue of 2**QUEUE_AW entries.
// The only case with two results (a held slash released together with the next byte,
// or with a second slash flushed at the end of the text) leaves the queue one result
// at a time; the queue absorbs that while input keeps flowing. in_stall rises when
// the queue could not take two more results from the item in flight and the next. The user
// must write allow_comments through the cfg port while the block is idle; unchecked.
module json_block_comment_stripper #(
	parameter int QUEUE_AW = jbcs_pkg::QUEUE_AW_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	// configuration write
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data,
	// input bytes
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	// results
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic       text_end
);
	import jbcs_pkg::*;

	localparam int DEPTH = 1 << QUEUE_AW;
	localparam int CNT_W = QUEUE_AW + 1;
	localparam int SUM_W = CNT_W + 1;

	logic             allow_q;
	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             last_s1;
	logic [2:0]       mode_q;
	logic [2:0]       mode_d;
	logic             pre_slash;
	logic             emit_byte;
	logic             post_slash;
	logic [1:0]       push_n;
	res_t             res0;
	res_t             res1;
	res_t             queue_q [DEPTH];
	logic [QUEUE_AW-1:0] head_q;
	logic [QUEUE_AW-1:0] tail_q;
	logic [CNT_W-1:0] count_q;
	logic             in_take;
	logic             out_take;
	logic [SUM_W-1:0] need;

	// config register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allow_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			allow_q <= cfg_data;
		end
	end

	// input register
	assign in_take = in_valid && !in_stall;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_take;
		end
	end
	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	// classify the registered byte against the scan mode
	always_comb begin
		pre_slash = 1'b0;
		emit_byte = 1'b0;
		mode_d    = mode_q;
		if (!allow_q) begin
			pre_slash = (mode_q == MODE_SLASH);
			emit_byte = 1'b1;
			mode_d    = MODE_NORMAL;
		end else begin
			unique case (mode_q)
				MODE_SLASH: begin
					if (byte_s1 == CHAR_STAR) begin
						mode_d = MODE_COMMENT;
					end else begin
						pre_slash = 1'b1;
						if (byte_s1 == CHAR_SLASH) begin
							mode_d = MODE_SLASH;
						end else begin
							emit_byte = 1'b1;
							mode_d    = (byte_s1 == CHAR_QUOTE) ? MODE_STRING : MODE_NORMAL;
						end
					end
				end
				MODE_STRING: begin
					emit_byte = 1'b1;
					if (byte_s1 == CHAR_BACKSLASH) begin
						mode_d = MODE_ESCAPE;
					end else if (byte_s1 == CHAR_QUOTE) begin
						mode_d = MODE_NORMAL;
					end
				end
				MODE_ESCAPE: begin
					emit_byte = 1'b1;
					mode_d    = MODE_STRING;
				end
				MODE_COMMENT: begin
					if (byte_s1 == CHAR_STAR) begin
						mode_d = MODE_STAR;
					end
				end
				MODE_STAR: begin
					if (byte_s1 == CHAR_SLASH) begin
						mode_d = MODE_NORMAL;
					end else if (byte_s1 != CHAR_STAR) begin
						mode_d = MODE_COMMENT;
					end
				end
				default: begin
					if (byte_s1 == CHAR_SLASH) begin
						mode_d = MODE_SLASH;
					end else begin
						emit_byte = 1'b1;
						mode_d    = (byte_s1 == CHAR_QUOTE) ? MODE_STRING : MODE_NORMAL;
					end
				end
			endcase
		end
		post_slash = last_s1 && (mode_d == MODE_SLASH);
	end

	// build up to two result requests
	always_comb begin
		res0 = '{data: 8'd0, byte_valid: 1'b0, text_end: 1'b0};
		res1 = '{data: 8'd0, byte_valid: 1'b0, text_end: 1'b0};
		push_n = 2'd0;
		if (pre_slash) begin
			res0 = '{data: CHAR_SLASH, byte_valid: 1'b1, text_end: 1'b0};
			push_n = 2'd1;
			if (emit_byte || post_slash) begin
				res1 = '{data: emit_byte ? byte_s1 : CHAR_SLASH, byte_valid: 1'b1,
					text_end: last_s1};
				push_n = 2'd2;
			end else begin
				res0.text_end = last_s1;
			end
		end else if (emit_byte || post_slash) begin
			res0 = '{data: emit_byte ? byte_s1 : CHAR_SLASH, byte_valid: 1'b1,
				text_end: last_s1};
			push_n = 2'd1;
		end else if (last_s1) begin
			// bare end marker
			res0 = '{data: 8'd0, byte_valid: 1'b0, text_end: 1'b1};
			push_n = 2'd1;
		end
		if (!valid_s1) begin
			push_n = 2'd0;
		end
	end

	// scan mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
		end else if (valid_s1) begin
			mode_q <= last_s1 ? MODE_NORMAL : mode_d;
		end
	end

	// result queue storage
	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			queue_q[tail_q] <= res0;
		end
		if (push_n == 2'd2) begin
			queue_q[tail_q + QUEUE_AW'(1)] <= res1;
		end
	end

	// result queue pointers and fill count
	assign out_take = out_valid && !out_stall;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			tail_q  <= tail_q + QUEUE_AW'(push_n);
			head_q  <= head_q + QUEUE_AW'(out_take);
			count_q <= count_q + CNT_W'(push_n) - CNT_W'(out_take);
		end
	end

	// room for two results from the item in flight and two from the next
	assign need     = SUM_W'(count_q) + (valid_s1 ? SUM_W'(2) : SUM_W'(0)) + SUM_W'(2);
	assign in_stall = need > SUM_W'(DEPTH);

	// output side
	assign out_valid  = count_q != '0;
	assign out_byte   = queue_q[head_q].data;
	assign byte_valid = queue_q[head_q].byte_valid;
	assign text_end   = queue_q[head_q].text_end;

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("result queue overflow");

	a_marker_ends_text: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !byte_valid |-> text_end && out_byte == 8'd0)
		else $error("bare result is not an end marker");

	a_last_resets_mode: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && last_s1 |=> mode_q == MODE_NORMAL)
		else $error("scan mode not normal after end of text");

	a_pass_through_mode: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !allow_q |=> mode_q == MODE_NORMAL)
		else $error("scan mode left normal while comments are passed");

	a_last_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && last_s1 |-> push_n != 2'd0)
		else $error("end of text produced no result");
`endif

endmodule
